@@ design/bpa_pkg.sv @@
// Package for the buddy page allocator: transfer types, command and status codes,
// default sizes. No dependencies; used by the allocator top level and the testbench.
`default_nettype none
package bpa_pkg;

	localparam int PAGE_COUNT_DEF = 65536;
	localparam int TOP_ORDER_DEF  = 10;

	localparam int CFG_W = 17;
	localparam logic [CFG_W-1:0] TOTAL_RESET = 17'd65536;

	localparam logic [1:0] KIND_ALLOC   = 2'd0;
	localparam logic [1:0] KIND_FREE    = 2'd1;
	localparam logic [1:0] KIND_REBUILD = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_EMPTY     = 2'd1;
	localparam logic [1:0] ST_BAD_ORDER = 2'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  order;
		logic [15:0] page;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] page_out;
	} rsp_t;

endpackage
`default_nettype wire

@@ design/bpa_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies; holds the link table of the buddy page allocator.
`default_nettype none
module bpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

@@ design/buddy_page_allocator.sv @@
// Top level of the buddy page allocator: free-list control and the link table.
// Depends on bpa_pkg and bpa_ram.
//
// Usage. A command is transferred at a rising edge with start high and busy low.
// Every command gives exactly one result: done is high for one cycle with result
// valid, and the receiver cannot hold it off. Free lists exist for orders 0 to
// TOP_ORDER; the list heads and their valid bits sit in registers, the next-links
// sit in a RAM of PAGE_COUNT entries with a registered read.
// Timing: a free, a bad order, an empty search or an unknown kind answers the
// cycle after the command (busy stays low). An allocate that finds a block of
// order f for request order k stays busy for one link read and then one link
// write per split, f - k splits in all; done follows as busy drops.
// A rebuild passes its init state, then hands out chunks in its run state, one link
// write each, stepping the order down when the remaining pages no longer fill a
// chunk of it; the rebuild ends once no pages remain.
// Reset: the lists are emptied and a rebuild of 65536 pages, or PAGE_COUNT if
// fewer, runs at once, with no result; busy is high until it ends. total_pages is
// written through its own channel, which is ready whenever the block is idle.
`default_nettype none
module buddy_page_allocator #(
	parameter int PAGE_COUNT = bpa_pkg::PAGE_COUNT_DEF,
	parameter int TOP_ORDER  = bpa_pkg::TOP_ORDER_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire bpa_pkg::req_t             cmd,
	output logic                           done,
	output bpa_pkg::rsp_t                  result,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [bpa_pkg::CFG_W-1:0] cfg_data
);

	localparam int PW = $clog2(PAGE_COUNT);
	localparam int IW = $clog2(TOP_ORDER + 1);
	localparam int NL = TOP_ORDER + 1;
	localparam int XW = ((PW > TOP_ORDER) ? PW : TOP_ORDER) + 2;

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_RB_INIT = 3'd1;
	localparam logic [2:0] S_RB_RUN  = 3'd2;
	localparam logic [2:0] S_POP     = 3'd3;
	localparam logic [2:0] S_SPLIT   = 3'd4;

	logic [2:0]            state_q;
	logic [NL-1:0]         nonempty_q;
	logic [PW-1:0]         head_q [NL];
	logic [bpa_pkg::CFG_W-1:0] total_q;
	logic [XW-1:0]         left_q;
	logic [XW-1:0]         base_q;
	logic [IW-1:0]         o_q;
	logic [IW-1:0]         cur_q;
	logic [IW-1:0]         ord_q;
	logic [PW-1:0]         got_q;
	logic                  reply_q;
	logic                  done_q;
	bpa_pkg::rsp_t         result_q;

	logic                  accept;
	logic                  order_bad;
	logic [NL-1:0]         avail;
	logic                  found_ok;
	logic [IW-1:0]         found_idx;
	logic [IW-1:0]         rd_idx;
	logic [PW-1:0]         head_rd;
	logic                  ne_rd;
	logic [XW-1:0]         chunk;
	logic [XW-1:0]         half;
	logic                  push_en;
	logic [PW-1:0]         push_pg;
	logic                  mem_re;
	logic [PW:0]           mem_wdata;
	logic [PW:0]           mem_rdata;

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = !busy;
	assign done      = done_q;
	assign result    = result_q;
	assign accept    = start && !busy;
	assign order_bad = 32'(cmd.order) > 32'(TOP_ORDER);

	// Lowest nonempty list at or above the requested order.
	always_comb begin
		found_ok  = 1'b0;
		found_idx = '0;
		for (int j = 0; j < NL; j++) begin
			avail[j] = nonempty_q[j] && (32'(j) >= 32'(cmd.order));
		end
		for (int j = NL - 1; j >= 0; j--) begin
			if (avail[j]) begin
				found_ok  = 1'b1;
				found_idx = IW'(j);
			end
		end
	end

	// One read port on the list heads, shared by search, push and rebuild.
	always_comb begin
		unique case (state_q)
			S_IDLE:   rd_idx = (cmd.kind == bpa_pkg::KIND_ALLOC) ? found_idx : IW'(cmd.order);
			S_SPLIT:  rd_idx = cur_q;
			S_RB_RUN: rd_idx = o_q;
			default:  rd_idx = cur_q;
		endcase
	end

	assign head_rd = head_q[rd_idx];
	assign ne_rd   = nonempty_q[rd_idx];
	assign chunk   = XW'(1) << o_q;
	assign half    = XW'(got_q) + (XW'(1) << cur_q);

	always_comb begin
		push_en = 1'b0;
		push_pg = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept && cmd.kind == bpa_pkg::KIND_FREE && !order_bad
					&& 32'(cmd.page) < 32'(PAGE_COUNT)) begin
					push_en = 1'b1;
					push_pg = PW'(cmd.page);
				end
			end
			S_SPLIT: begin
				// An upper half beyond the last page is dropped.
				if (32'(half) < 32'(PAGE_COUNT)) begin
					push_en = 1'b1;
					push_pg = PW'(half);
				end
			end
			S_RB_RUN: begin
				if (left_q != '0 && left_q >= chunk) begin
					push_en = 1'b1;
					push_pg = PW'(base_q);
				end
			end
			default: begin
				push_en = 1'b0;
			end
		endcase
	end

	assign mem_wdata = ne_rd ? {head_rd, 1'b1} : '0;
	assign mem_re    = accept && cmd.kind == bpa_pkg::KIND_ALLOC && !order_bad && found_ok;

	bpa_ram #(
		.WIDTH(PW + 1),
		.DEPTH(PAGE_COUNT)
	) u_link (
		.clk  (clk),
		.we   (push_en),
		.waddr(push_pg),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(head_rd),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk) begin
		if (push_en) begin
			head_q[rd_idx] <= push_pg;
		end else if (state_q == S_POP) begin
			head_q[cur_q] <= mem_rdata[PW:1];
		end
		if (mem_re) begin
			got_q <= head_rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_RB_INIT;
			nonempty_q <= '0;
			total_q    <= bpa_pkg::TOTAL_RESET;
			left_q     <= '0;
			base_q     <= '0;
			o_q        <= '0;
			cur_q      <= '0;
			ord_q      <= '0;
			reply_q    <= 1'b0;
			done_q     <= 1'b0;
			result_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				total_q <= cfg_data;
			end
			if (push_en) begin
				nonempty_q[rd_idx] <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (cmd.kind)
							bpa_pkg::KIND_ALLOC: begin
								if (order_bad) begin
									done_q   <= 1'b1;
									result_q <= '{status: bpa_pkg::ST_BAD_ORDER, page_out: '0};
								end else if (!found_ok) begin
									done_q   <= 1'b1;
									result_q <= '{status: bpa_pkg::ST_EMPTY, page_out: '0};
								end else begin
									cur_q   <= found_idx;
									ord_q   <= IW'(cmd.order);
									state_q <= S_POP;
								end
							end
							bpa_pkg::KIND_FREE: begin
								done_q   <= 1'b1;
								result_q <= '{status: order_bad ? bpa_pkg::ST_BAD_ORDER
									: bpa_pkg::ST_OK, page_out: '0};
							end
							bpa_pkg::KIND_REBUILD: begin
								reply_q <= 1'b1;
								state_q <= S_RB_INIT;
							end
							default: begin
								done_q   <= 1'b1;
								result_q <= '{status: bpa_pkg::ST_OK, page_out: '0};
							end
						endcase
					end
				end
				S_RB_INIT: begin
					nonempty_q <= '0;
					left_q     <= (32'(total_q) > 32'(PAGE_COUNT)) ? XW'(PAGE_COUNT)
						: XW'(total_q);
					base_q     <= '0;
					o_q        <= IW'(TOP_ORDER);
					state_q    <= S_RB_RUN;
				end
				S_RB_RUN: begin
					// Chunks shrink from the top order down; the order steps down
					// once the remaining pages no longer fill a chunk of it.
					if (left_q == '0) begin
						if (reply_q) begin
							done_q   <= 1'b1;
							result_q <= '{status: bpa_pkg::ST_OK, page_out: '0};
						end
						reply_q <= 1'b0;
						state_q <= S_IDLE;
					end else if (left_q >= chunk) begin
						left_q <= left_q - chunk;
						base_q <= base_q + chunk;
					end else begin
						o_q <= o_q - 1'b1;
					end
				end
				S_POP: begin
					nonempty_q[cur_q] <= mem_rdata[0];
					if (cur_q == ord_q) begin
						done_q   <= 1'b1;
						result_q <= '{status: bpa_pkg::ST_OK, page_out: 16'(got_q)};
						state_q  <= S_IDLE;
					end else begin
						cur_q   <= cur_q - 1'b1;
						state_q <= S_SPLIT;
					end
				end
				S_SPLIT: begin
					if (cur_q == ord_q) begin
						done_q   <= 1'b1;
						result_q <= '{status: bpa_pkg::ST_OK, page_out: 16'(got_q)};
						state_q  <= S_IDLE;
					end else begin
						cur_q <= cur_q - 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// A result is only ever given while the block is idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// An allocate above the top order answers at once with the order error.
	a_bad_order: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd.kind == bpa_pkg::KIND_ALLOC && 32'(cmd.order) > 32'(TOP_ORDER))
		|=> (done && result.status == bpa_pkg::ST_BAD_ORDER && !busy))
		else $error("order error not reported");

	// The link read lands in the pop cycle, which must not also write the table.
	a_pop_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POP) |-> (!push_en && $past(mem_re)))
		else $error("link table written or unread during pop");

	// A split never pushes onto the list that was just popped or a larger one.
	a_split_lower: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SPLIT && $past(state_q) == S_SPLIT) |-> (cur_q < $past(cur_q)))
		else $error("split order did not descend");

endmodule
`default_nettype wire

@@ tb/tb_buddy_page_allocator.sv @@
// Self-checking testbench for buddy_page_allocator: directed and random commands,
// total_pages writes and a free-list predictor in a small scoreboard class.
// Depends on bpa_pkg and the allocator RTL.
`timescale 1ns / 1ps
module tb_buddy_page_allocator;

	localparam int PAGES = bpa_pkg::PAGE_COUNT_DEF;
	localparam int TOP = bpa_pkg::TOP_ORDER_DEF;
	localparam logic [1:0] KIND_UNKNOWN = 2'd3;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASE_ITEMS = 170;

	class page_pool_model;
		logic [bpa_pkg::CFG_W-1:0] total_pages;
		logic [15:0] list_head [TOP+1];
		bit list_full [TOP+1];
		logic [16:0] link_next [PAGES];
		bpa_pkg::rsp_t replies_due [$];
		logic [15:0] held_page [$];
		logic [3:0] held_order [$];
		int mismatches;

		function new();
			foreach (link_next[i]) link_next[i] = '0;
			total_pages = bpa_pkg::TOTAL_RESET;
			mismatches = 0;
			rebuild_lists();
		endfunction

		function void push_block(int unsigned pg, int ord);
			if (pg >= PAGES || ord > TOP) return;
			link_next[pg] = list_full[ord] ? {list_head[ord], 1'b1} : 17'd0;
			list_head[ord] = pg[15:0];
			list_full[ord] = 1'b1;
		endfunction

		function void rebuild_lists();
			int unsigned left;
			int unsigned base;
			int ord;
			left = (total_pages > PAGES) ? PAGES : 32'(total_pages);
			base = 0;
			for (int i = 0; i <= TOP; i++) begin
				list_head[i] = '0;
				list_full[i] = 1'b0;
			end
			held_page.delete();
			held_order.delete();
			while (left > 0) begin
				ord = 0;
				while ((32'd1 << (ord + 1)) <= left) ord++;
				if (ord > TOP) ord = TOP;
				push_block(base, ord);
				base += 32'd1 << ord;
				left -= 32'd1 << ord;
			end
		endfunction

		function bpa_pkg::rsp_t predict_reply(bpa_pkg::req_t c);
			bpa_pkg::rsp_t r;
			int ord;
			int lvl;
			int unsigned got;
			logic [16:0] lk;
			r.status = bpa_pkg::ST_OK;
			r.page_out = '0;
			ord = int'(c.order);
			case (c.kind)
				bpa_pkg::KIND_ALLOC: begin
					if (ord > TOP) begin
						r.status = bpa_pkg::ST_BAD_ORDER;
					end else begin
						lvl = ord;
						while (lvl <= TOP && !list_full[lvl]) lvl++;
						if (lvl > TOP) begin
							r.status = bpa_pkg::ST_EMPTY;
						end else begin
							got = 32'(list_head[lvl]);
							lk = link_next[got];
							list_full[lvl] = lk[0];
							list_head[lvl] = lk[0] ? lk[16:1] : 16'd0;
							// Upper halves go down one list at a time; past the end they are lost.
							while (lvl > ord) begin
								lvl--;
								push_block(got + (32'd1 << lvl), lvl);
							end
							r.page_out = got[15:0];
							held_page.push_back(got[15:0]);
							held_order.push_back(c.order);
						end
					end
				end
				bpa_pkg::KIND_FREE: begin
					if (ord > TOP) r.status = bpa_pkg::ST_BAD_ORDER;
					else push_block(32'(c.page), ord);
				end
				bpa_pkg::KIND_REBUILD: rebuild_lists();
				default: ;
			endcase
			return r;
		endfunction

		function void note_command(bpa_pkg::req_t c);
			replies_due.push_back(predict_reply(c));
		endfunction

		task report(string what);
			mismatches++;
			if (mismatches <= 100) $display("MISMATCH at %0t: %s", $realtime, what);
		endtask

		task check_reply(bpa_pkg::rsp_t got);
			bpa_pkg::rsp_t want;
			if (replies_due.size() == 0) begin
				report($sformatf("result with nothing expected: status %0d page %0d",
					got.status, got.page_out));
			end else begin
				want = replies_due.pop_front();
				if (got.status !== want.status)
					report($sformatf("status %0d, expected %0d", got.status, want.status));
				if (got.page_out !== want.page_out)
					report($sformatf("page_out %0d, expected %0d", got.page_out,
						want.page_out));
			end
		endtask

		// Hands back a block that is currently allocated, so that frees are mostly sensible.
		function bit take_held(output logic [15:0] pg, output logic [3:0] ord);
			int idx;
			if (held_page.size() == 0) return 1'b0;
			idx = $urandom_range(held_page.size() - 1);
			pg = held_page[idx];
			ord = held_order[idx];
			held_page.delete(idx);
			held_order.delete(idx);
			return 1'b1;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	bpa_pkg::req_t cmd;
	logic done;
	bpa_pkg::rsp_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [bpa_pkg::CFG_W-1:0] cfg_data;

	page_pool_model pool;
	int idle_pct;
	int cycles;

	buddy_page_allocator u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ($isunknown(done) || $isunknown(busy) || $isunknown(cfg_ready))
				pool.report("unknown value on a control output");
			if (done === 1'b1) pool.check_reply(result);
			if (start && busy === 1'b0) pool.note_command(cmd);
			if (cfg_valid && cfg_ready === 1'b1) pool.total_pages = cfg_data;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("buddy_page_allocator verification failed");
			$finish;
		end
	end

	function automatic bpa_pkg::req_t mk(logic [1:0] k, int o, logic [15:0] p);
		bpa_pkg::req_t c;
		c.kind = k;
		c.order = 4'(o);
		c.page = p;
		return c;
	endfunction

	task automatic send(bpa_pkg::req_t c);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (pool.replies_due.size() != 0) @(posedge clk);
	endtask

	// Every command answers, so once the queue is empty the block is idle.
	task automatic write_total(logic [bpa_pkg::CFG_W-1:0] v);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_item();
		bpa_pkg::req_t c;
		int r;
		logic [15:0] pg;
		logic [3:0] ord;
		r = $urandom_range(99);
		c.kind = bpa_pkg::KIND_ALLOC;
		c.order = 4'($urandom_range(TOP));
		c.page = 16'($urandom);
		if (r < 45) begin
			c.kind = bpa_pkg::KIND_ALLOC;
		end else if (r < 82) begin
			c.kind = bpa_pkg::KIND_FREE;
			if (pool.take_held(pg, ord)) begin
				c.page = pg;
				c.order = ord;
			end
		end else if (r < 88) begin
			c.kind = bpa_pkg::KIND_FREE;
		end else if (r < 93) begin
			c.kind = $urandom_range(1) ? bpa_pkg::KIND_ALLOC : bpa_pkg::KIND_FREE;
			c.order = 4'($urandom_range(15, TOP + 1));
		end else if (r < 97) begin
			c.kind = KIND_UNKNOWN;
			c.order = 4'($urandom_range(15));
		end else begin
			c.kind = bpa_pkg::KIND_REBUILD;
		end
		send(c);
	endtask

	initial begin
		logic [bpa_pkg::CFG_W-1:0] totals [6];
		int idles [6];
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		idle_pct = 0;
		cycles = 0;
		pool = new();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part: extremes, bad orders, unknown kind, LIFO reuse, splits past
		// the last page, a self-linked list after a double free, and rebuild sizes.
		send(mk(bpa_pkg::KIND_ALLOC, 0, 16'h0000));
		send(mk(bpa_pkg::KIND_ALLOC, TOP, 16'hFFFF));
		send(mk(bpa_pkg::KIND_ALLOC, TOP + 1, 16'h0000));
		send(mk(bpa_pkg::KIND_ALLOC, 15, 16'hFFFF));
		send(mk(bpa_pkg::KIND_FREE, 15, 16'hFFFF));
		send(mk(bpa_pkg::KIND_FREE, TOP + 1, 16'h0000));
		send(mk(KIND_UNKNOWN, 15, 16'hFFFF));
		send(mk(KIND_UNKNOWN, 0, 16'h0000));
		send(mk(bpa_pkg::KIND_FREE, 0, 16'h0000));
		send(mk(bpa_pkg::KIND_ALLOC, 0, 16'h0000));
		write_total('0);
		send(mk(bpa_pkg::KIND_REBUILD, 0, 16'h0000));
		send(mk(bpa_pkg::KIND_ALLOC, 0, 16'h0000));
		send(mk(bpa_pkg::KIND_FREE, TOP, 16'hFFFF));
		send(mk(bpa_pkg::KIND_ALLOC, 0, 16'h0000));
		send(mk(bpa_pkg::KIND_FREE, 0, 16'hFFFF));
		send(mk(bpa_pkg::KIND_FREE, 0, 16'hFFFF));
		repeat (3) send(mk(bpa_pkg::KIND_ALLOC, 0, 16'h0000));
		send(mk(bpa_pkg::KIND_ALLOC, TOP, 16'h0000));
		write_total(17'd1);
		send(mk(bpa_pkg::KIND_REBUILD, 0, 16'h0000));
		send(mk(bpa_pkg::KIND_ALLOC, 0, 16'h0000));
		send(mk(bpa_pkg::KIND_ALLOC, 0, 16'h0000));
		write_total(17'h1FFFF);
		send(mk(bpa_pkg::KIND_REBUILD, 15, 16'hFFFF));
		send(mk(bpa_pkg::KIND_ALLOC, TOP, 16'h0000));

		totals[0] = bpa_pkg::TOTAL_RESET;
		totals[1] = 17'($urandom_range(2048, 1));
		totals[2] = 17'h1FFFF;
		totals[3] = 17'($urandom_range(65535, 2049));
		totals[4] = 17'($urandom_range(17'h1FFFF, 0));
		totals[5] = 17'd3;
		idles[0] = 0;
		idles[1] = 80;
		idles[2] = 14;
		idles[3] = 80;
		idles[4] = 0;
		idles[5] = 14;
		for (int ph = 0; ph < 6; ph++) begin
			write_total(totals[ph]);
			idle_pct = idles[ph];
			send(mk(bpa_pkg::KIND_REBUILD, 0, 16'h0000));
			repeat (PHASE_ITEMS) random_item();
		end

		drain();
		repeat (120) @(posedge clk);
		if (pool.mismatches == 0 && pool.replies_due.size() == 0) begin
			$display("buddy_page_allocator verification clean");
		end else begin
			$display("buddy_page_allocator verification failed");
		end
		$finish;
	end

endmodule
